// File: hw/rtl/sws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_pkg
// Types, codes and small helper functions shared by the square-wave channel.
// ----------------------------------------------------------------------------
package sws_pkg;

	localparam int unsigned NUM_DUTY   = 4;
	localparam int unsigned WAVE_STEPS = 8;

	// item operation codes
	typedef enum logic [2:0] {
		OP_WRITE      = 3'd0,
		OP_READ       = 3'd1,
		OP_FREQ_TICK  = 3'd2,
		OP_LEN_TICK   = 3'd3,
		OP_ENV_TICK   = 3'd4,
		OP_SWEEP_TICK = 3'd5,
		OP_CLEAR      = 3'd6,
		OP_NONE       = 3'd7
	} sws_op_t;

	// channel register indexes
	localparam logic [2:0] REG_SWEEP    = 3'd0;
	localparam logic [2:0] REG_DUTY_LEN = 3'd1;
	localparam logic [2:0] REG_ENVELOPE = 3'd2;
	localparam logic [2:0] REG_FREQ_LO  = 3'd3;
	localparam logic [2:0] REG_FREQ_HI  = 3'd4;

	localparam logic [11:0] FREQ_LIMIT   = 12'd2048;
	localparam logic [6:0]  LENGTH_FULL  = 7'd64;
	localparam logic [3:0]  TIMER_DEFAULT = 4'd8;
	localparam logic [3:0]  LEVEL_MAX    = 4'd15;
	localparam logic [7:0]  READ_IDLE    = 8'hFF;

	// duty register reset values
	localparam logic [7:0] DUTY_WAVE_0_RST = 8'h01;
	localparam logic [7:0] DUTY_WAVE_1_RST = 8'h81;
	localparam logic [7:0] DUTY_WAVE_2_RST = 8'h87;
	localparam logic [7:0] DUTY_WAVE_3_RST = 8'h7E;

	typedef struct packed {
		sws_op_t    operation;
		logic [2:0] reg_index;
		logic [7:0] write_value;
	} sws_item_t;

	typedef struct packed {
		logic [15:0] period_timer;
		logic [2:0]  wave_step;
		logic [6:0]  length_counter;
		logic        length_stop;
		logic        running;
		logic        dac_on;
		logic [3:0]  envelope_timer;
		logic [2:0]  envelope_period;
		logic        envelope_up;
		logic [3:0]  start_volume;
		logic [3:0]  level;
		logic        envelope_running;
		logic [3:0]  sweep_timer;
		logic [2:0]  sweep_period;
		logic        sweep_down;
		logic [2:0]  sweep_shift;
		logic        sweep_running;
		logic [10:0] shadow_frequency;
		logic [10:0] frequency;
		logic [1:0]  duty_select;
	} sws_state_t;

	// timer reload for a frequency: (2048 - f) * 4, always below 2^14
	function automatic logic [15:0] period_load(input logic [10:0] freq);
		logic [11:0] diff;
		diff = FREQ_LIMIT - {1'b0, freq};
		return {2'b00, diff, 2'b00};
	endfunction

	// a zero period reloads with eight
	function automatic logic [3:0] timer_reload(input logic [2:0] period);
		return (period != 3'd0) ? {1'b0, period} : TIMER_DEFAULT;
	endfunction

	// next sweep frequency, may reach 2048 or more when sweeping up
	function automatic logic [11:0] sweep_calc(input logic [10:0] shadow,
			input logic [2:0] shift, input logic down);
		logic [11:0] delta;
		delta = {1'b0, shadow} >> shift;
		return down ? ({1'b0, shadow} - delta) : ({1'b0, shadow} + delta);
	endfunction

endpackage

// File: hw/rtl/square_wave_channel_with_sweep_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_wave_channel_with_sweep_core
// Square-wave sound channel with frequency sweep, envelope and length counter.
// ----------------------------------------------------------------------------
// Each input word (register write or read, one of the four ticks, or clear)
// is taken into an input register and, once the output register is free or
// drains, applied to the channel state in a single pass of logic while its
// result word is loaded into the output register. A new word is accepted
// every cycle as long as the output side keeps draining. The duty waveform
// registers are to be written through the configuration port only while no
// word is in flight; the user must keep to this, the block does not enforce it.
module square_wave_channel_with_sweep_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] operation,
	input  logic [2:0] reg_index,
	input  logic [7:0] write_value,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data,
	output logic [3:0] sample,
	output logic       channel_on,
	input  logic       cfg_write_en,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import sws_pkg::*;

	sws_item_t  item_s1;
	logic       valid_s1;
	sws_state_t state_q;
	sws_state_t state_nxt;
	logic [7:0] read_byte;
	logic       wave_bit;
	logic       advance;
	logic       in_take;

	// word moves to the output register when that register is free or drains
	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.operation   <= sws_op_t'(operation);
			item_s1.reg_index   <= reg_index;
			item_s1.write_value <= write_value;
		end
	end

	sws_step u_step (
		.state_cur (state_q),
		.item      (item_s1),
		.state_nxt (state_nxt),
		.read_byte (read_byte)
	);

	sws_duty u_duty (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.duty_select  (state_nxt.duty_select),
		.wave_step    (state_nxt.wave_step),
		.wave_bit     (wave_bit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= '0;
			out_valid <= 1'b0;
		end else if (advance) begin
			state_q   <= state_nxt;
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data  <= read_byte;
			sample     <= (state_nxt.running && state_nxt.dac_on && wave_bit) ?
				state_nxt.level : 4'd0;
			channel_on <= state_nxt.running;
		end
	end

endmodule

// File: hw/rtl/sws_duty.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_duty
// Duty waveform registers with write port, and waveform bit lookup.
// ----------------------------------------------------------------------------
module sws_duty (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write_en,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic [1:0] duty_select,
	input  logic [2:0] wave_step,
	output logic       wave_bit
);
	import sws_pkg::*;

	logic [NUM_DUTY-1:0][7:0] duty_wave_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_wave_q[0] <= DUTY_WAVE_0_RST;
			duty_wave_q[1] <= DUTY_WAVE_1_RST;
			duty_wave_q[2] <= DUTY_WAVE_2_RST;
			duty_wave_q[3] <= DUTY_WAVE_3_RST;
		end else if (cfg_write_en) begin
			duty_wave_q[cfg_index] <= cfg_data;
		end
	end

	assign wave_bit = duty_wave_q[duty_select][wave_step];

endmodule

// File: hw/rtl/sws_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_step
// Next-state and read-byte logic for one channel word.
// ----------------------------------------------------------------------------
module sws_step (
	input  sws_pkg::sws_state_t state_cur,
	input  sws_pkg::sws_item_t  item,
	output sws_pkg::sws_state_t state_nxt,
	output logic [7:0]          read_byte
);
	import sws_pkg::*;

	sws_state_t  s;
	logic [11:0] sweep_res;
	logic [7:0]  v;

	always_comb begin
		s         = state_cur;
		v         = item.write_value;
		read_byte = READ_IDLE;
		sweep_res = '0;
		case (item.operation)
			OP_WRITE: begin
				unique case (item.reg_index)
					REG_SWEEP: begin
						s.sweep_shift  = v[2:0];
						s.sweep_down   = v[3];
						s.sweep_period = v[6:4];
					end
					REG_DUTY_LEN: begin
						s.length_counter = LENGTH_FULL - {1'b0, v[5:0]};
						s.duty_select    = v[7:6];
					end
					REG_ENVELOPE: begin
						s.envelope_period = v[2:0];
						s.envelope_up     = v[3];
						s.start_volume    = v[7:4];
						s.dac_on          = (v[7:4] != 4'd0) || v[3];
					end
					REG_FREQ_LO: begin
						s.frequency    = {s.frequency[10:8], v};
						s.period_timer = period_load(s.frequency);
					end
					REG_FREQ_HI: begin
						s.frequency    = {v[2:0], s.frequency[7:0]};
						s.period_timer = period_load(s.frequency);
						s.length_stop  = v[6];
						if (v[7]) begin
							s.running = 1'b1;
							if (s.length_counter == 7'd0) begin
								s.length_counter = LENGTH_FULL;
							end
							s.envelope_running = (s.start_volume != 4'd0) || s.envelope_up;
							s.envelope_timer   = timer_reload(s.envelope_period);
							s.level            = s.start_volume;
							s.shadow_frequency = s.frequency;
							s.sweep_timer      = timer_reload(s.sweep_period);
							s.sweep_running    = (s.sweep_period != 3'd0) ||
								(s.sweep_shift != 3'd0);
							// overflow check only, result not stored
							if (s.sweep_shift != 3'd0) begin
								sweep_res = sweep_calc(s.shadow_frequency, s.sweep_shift,
									s.sweep_down);
								if (sweep_res >= FREQ_LIMIT) begin
									s.running = 1'b0;
								end
							end
						end
					end
					default: begin
					end
				endcase
			end
			OP_READ: begin
				unique case (item.reg_index)
					REG_SWEEP:    read_byte = {1'b1, s.sweep_period, s.sweep_down, s.sweep_shift};
					REG_DUTY_LEN: read_byte = {s.duty_select, 6'h3F};
					REG_ENVELOPE: read_byte = {s.start_volume, s.envelope_up, s.envelope_period};
					REG_FREQ_HI:  read_byte = {1'b1, s.length_stop, 3'b000, s.frequency[10:8]};
					default:      read_byte = READ_IDLE;
				endcase
			end
			OP_FREQ_TICK: begin
				s.period_timer = s.period_timer - 16'd1;
				if (s.period_timer == 16'd0) begin
					s.period_timer = period_load(s.frequency);
					s.wave_step    = s.wave_step + 3'd1;
				end
			end
			OP_LEN_TICK: begin
				if ((s.length_counter != 7'd0) && s.length_stop) begin
					s.length_counter = s.length_counter - 7'd1;
					if (s.length_counter == 7'd0) begin
						s.running = 1'b0;
					end
				end
			end
			OP_ENV_TICK: begin
				s.envelope_timer = s.envelope_timer - 4'd1;
				if (s.envelope_timer == 4'd0) begin
					s.envelope_timer = timer_reload(s.envelope_period);
					if (s.envelope_running && (s.envelope_period != 3'd0)) begin
						if (s.envelope_up) begin
							if (s.level < LEVEL_MAX) s.level = s.level + 4'd1;
						end else begin
							if (s.level != 4'd0) s.level = s.level - 4'd1;
						end
					end
					if ((s.level == 4'd0) || (s.level == LEVEL_MAX)) begin
						s.envelope_running = 1'b0;
					end
				end
			end
			OP_SWEEP_TICK: begin
				s.sweep_timer = s.sweep_timer - 4'd1;
				if (s.sweep_timer == 4'd0) begin
					s.sweep_timer = timer_reload(s.sweep_period);
					if (s.sweep_running && (s.sweep_period != 3'd0)) begin
						sweep_res = sweep_calc(s.shadow_frequency, s.sweep_shift, s.sweep_down);
						if (sweep_res >= FREQ_LIMIT) begin
							s.running = 1'b0;
						end else if (s.sweep_shift != 3'd0) begin
							s.shadow_frequency = sweep_res[10:0];
							s.frequency        = sweep_res[10:0];
							s.period_timer     = period_load(sweep_res[10:0]);
						end
					end
				end
			end
			OP_CLEAR: begin
				s = '0;
			end
			default: begin
			end
		endcase
		state_nxt = s;
	end

endmodule
